>>> hdl/srld_pkg.sv
// Shared types and constants for the sprite run-length decoder.
package srld_pkg;

  // Default of the largest sprite dimension
  localparam int MaxDimDefault = 1024;

  // Fixed field widths
  localparam int TypeW   = 2;
  localparam int DimCfgW = 11;
  localparam int ByteW   = 8;
  localparam int CountW  = 9;
  localparam int PosW    = 10;
  localparam int StatusW = 2;

  // Depth of the byte queue between front and back
  localparam int QueueDepth = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_TYPE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // Sprite codings
  localparam logic [TypeW-1:0] TYPE_RAW  = 2'd0;
  localparam logic [TypeW-1:0] TYPE_PAIR = 2'd1;
  localparam logic [TypeW-1:0] TYPE_SKIP = 2'd2;
  localparam logic [TypeW-1:0] TYPE_PACK = 2'd3;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK         = 2'd0;
  localparam logic [StatusW-1:0] ST_SHORT_SKIP = 2'd2;

  // Coding constants
  localparam logic [ByteW-1:0] PAIR_LITERAL = 8'd255;
  localparam logic [ByteW-1:0] PACK_HELD    = 8'd7;
  localparam logic [2:0]       PACK_LITERAL = 3'b111;
  localparam logic [15:0]      MIN_SKIP     = 16'd2;

  // Decoder phases
  typedef enum logic [7:0] {
    PH_RAW  = 8'b0000_0001,
    PH_SKIP = 8'b0000_0010,
    PH_PVAL = 8'b0000_0100,
    PH_PLEN = 8'b0000_1000,
    PH_LIT  = 8'b0001_0000,
    PH_SKLO = 8'b0010_0000,
    PH_SKHI = 8'b0100_0000,
    PH_PACK = 8'b1000_0000
  } phase_t;

  // One queued input byte
  typedef struct packed {
    logic             start;
    logic [ByteW-1:0] data;
  } byte_item_t;

  // Configuration registers as seen by the decoder
  typedef struct packed {
    logic [TypeW-1:0]   sprite_type;
    logic [DimCfgW-1:0] sprite_width;
    logic [DimCfgW-1:0] sprite_height;
  } cfg_t;

endpackage

>>> hdl/sprite_run_length_decoder_core.sv
// Sprite run-length decoder top level: configuration registers, byte queue and decoder.
//
// Usage: compressed sprite body bytes enter on the byte channel (stream_byte,
// start_sprite, byte_valid, byte_stall); a byte with start_sprite set restarts
// decoding at row 0 with the current configuration. Pixel runs leave on the run
// channel (pixel_value, run_count, pos_x, pos_y, last, status, run_valid,
// run_stall), at most one run per byte.
// Configuration: sprite_type (index 0), sprite_width (1), sprite_height (2) are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write them
// only while no byte is in flight, which the block does not enforce. cfg_ready is
// always high and unknown indexes are ignored.
// Throughput: one byte per cycle while run_stall does not hold the result register.
// A byte is queued, then decoded from the queue head into the result register.
// Stalls: a four-entry byte queue separates input from decoding; while
// run_stall holds the result register, the queue keeps taking bytes until full.
// Reset: queue empty, no run pending, coding raw, width and height 1.
module sprite_run_length_decoder_core import srld_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [ByteW-1:0]   stream_byte,
  input  logic               start_sprite,
  input  logic               byte_valid,
  output logic               byte_stall,
  output logic [ByteW-1:0]   pixel_value,
  output logic [CountW-1:0]  run_count,
  output logic [PosW-1:0]    pos_x,
  output logic [PosW-1:0]    pos_y,
  output logic               last,
  output logic [StatusW-1:0] status,
  output logic               run_valid,
  input  logic               run_stall,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [DimCfgW-1:0] cfg_data
);

  cfg_t       cfg;
  byte_item_t item;
  logic       item_valid;
  logic       item_take;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sprite_type   <= TYPE_RAW;
      cfg.sprite_width  <= DimCfgW'(1);
      cfg.sprite_height <= DimCfgW'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TYPE:   cfg.sprite_type   <= cfg_data[TypeW-1:0];
        CFG_WIDTH:  cfg.sprite_width  <= cfg_data;
        CFG_HEIGHT: cfg.sprite_height <= cfg_data;
        default: ;
      endcase
    end
  end

  srld_front u_front (
    .clk          (clk),
    .rst          (rst),
    .stream_byte  (stream_byte),
    .start_sprite (start_sprite),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .item         (item),
    .item_valid   (item_valid),
    .item_take    (item_take)
  );

  srld_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item        (item),
    .item_valid  (item_valid),
    .item_take   (item_take),
    .pixel_value (pixel_value),
    .run_count   (run_count),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .last        (last),
    .status      (status),
    .run_valid   (run_valid),
    .run_stall   (run_stall)
  );

endmodule

>>> hdl/srld_front.sv
// Input side of the decoder: accepts bytes and queues them for the back end.
module srld_front import srld_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [ByteW-1:0] stream_byte,
  input  logic             start_sprite,
  input  logic             byte_valid,
  output logic             byte_stall,
  output byte_item_t       item,
  output logic             item_valid,
  input  logic             item_take
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  byte_item_t          queue [QueueDepth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic [CntW-1:0]     count_next;
  logic                push;
  logic                pop;

  // Stall while the queue is full
  assign byte_stall = (count == CntW'(QueueDepth));
  assign push       = byte_valid && !byte_stall;
  assign pop        = item_take && item_valid;
  assign item_valid = (count != '0);
  assign item       = queue[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CntW'(1);
    end else if (pop && !push) begin
      count_next = count - CntW'(1);
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
    end
  end

  // Store the incoming byte
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= '{start: start_sprite, data: stream_byte};
    end
  end

endmodule

>>> hdl/srld_back.sv
// Decode side: runs the sprite decoding state machine and holds the result register.
module srld_back import srld_pkg::*; #(
  parameter int MAX_DIM = MaxDimDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  byte_item_t         item,
  input  logic               item_valid,
  output logic               item_take,
  output logic [ByteW-1:0]   pixel_value,
  output logic [CountW-1:0]  run_count,
  output logic [PosW-1:0]    pos_x,
  output logic [PosW-1:0]    pos_y,
  output logic               last,
  output logic [StatusW-1:0] status,
  output logic               run_valid,
  input  logic               run_stall
);

  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int CMPW = (DW > CountW) ? DW : CountW;
  localparam int SKW  = (DW + 2 > 16) ? DW + 2 : 16;

  // Decoder state
  phase_t            phase;
  logic [DW-1:0]     col;
  logic [DW-1:0]     row;
  logic [CountW-1:0] literal_left;
  logic [ByteW-1:0]  held_value;
  logic [SKW-1:0]    skip_left;
  logic              done;

  phase_t            phase_next;
  logic [DW-1:0]     col_next;
  logic [DW-1:0]     row_next;
  logic [CountW-1:0] literal_left_next;
  logic [ByteW-1:0]  held_value_next;
  logic [SKW-1:0]    skip_left_next;
  logic              done_next;

  // State after an optional restart
  phase_t            cur_phase;
  logic [DW-1:0]     cur_col;
  logic [DW-1:0]     cur_row;
  logic [CountW-1:0] cur_lit;
  logic [ByteW-1:0]  cur_held;
  logic [SKW-1:0]    cur_skip;
  logic              cur_done;

  logic [DW-1:0]     w_c;
  logic [DW-1:0]     h_c;
  logic [ByteW-1:0]  b;

  // Run request and clipping
  logic              em_req;
  logic [ByteW-1:0]  em_val;
  logic [CountW-1:0] em_len;
  logic              eor_req;
  logic              err;
  logic [CMPW-1:0]   avail;
  logic [CMPW-1:0]   len_x;
  logic [CountW-1:0] cnt;
  logic              emit;
  logic [CMPW-1:0]   col_sum;
  logic [DW-1:0]     col_after;
  logic [DW:0]       row_p1;
  logic              lst;
  logic [SKW-1:0]    skip_dec;
  logic [CountW-1:0] lit_dec;
  logic [15:0]       skip_len;
  logic              fire;

  function automatic logic [DW-1:0] clamp_dim(input logic [DimCfgW-1:0] v);
    logic [16:0] vx;
    vx = 17'(v);
    if (v == '0) begin
      return DW'(1);
    end else if (vx > 17'(MAX_DIM)) begin
      return DW'(MAX_DIM);
    end
    return vx[DW-1:0];
  endfunction

  assign w_c = clamp_dim(cfg.sprite_width);
  assign h_c = clamp_dim(cfg.sprite_height);
  assign b   = item.data;

  // Take a byte when the result register is free or being drained
  assign item_take = item_valid && (!run_valid || !run_stall);

  // Restart at row 0 when the byte opens a new sprite
  always_comb begin
    cur_phase = phase;
    cur_col   = col;
    cur_row   = row;
    cur_lit   = literal_left;
    cur_held  = held_value;
    cur_skip  = skip_left;
    cur_done  = done;
    if (item.start) begin
      cur_col  = '0;
      cur_row  = '0;
      cur_lit  = '0;
      cur_held = '0;
      cur_skip = '0;
      cur_done = 1'b0;
      unique case (cfg.sprite_type)
        TYPE_RAW:  cur_phase = PH_RAW;
        TYPE_PAIR: begin
          cur_phase = PH_SKIP;
          cur_held  = PAIR_LITERAL;
          cur_skip  = SKW'({h_c, 2'b00});
        end
        TYPE_SKIP: cur_phase = PH_SKLO;
        default:   cur_phase = PH_PACK;
      endcase
    end
  end

  // Decode one byte
  always_comb begin
    phase_next        = cur_phase;
    literal_left_next = cur_lit;
    held_value_next   = cur_held;
    skip_left_next    = cur_skip;
    done_next         = cur_done;
    em_req            = 1'b0;
    em_val            = b;
    em_len            = CountW'(1);
    eor_req           = 1'b0;
    err               = 1'b0;
    skip_dec          = (cur_skip != '0) ? cur_skip - SKW'(1) : cur_skip;
    lit_dec           = (cur_lit != '0) ? cur_lit - CountW'(1) : cur_lit;
    skip_len          = {b, cur_held};

    if (!cur_done) begin
      unique case (cur_phase)
        PH_RAW: begin
          em_req  = 1'b1;
          eor_req = 1'b1;
        end
        PH_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = (cur_held == PAIR_LITERAL) ? PH_PVAL : PH_PACK;
          end
        end
        PH_PVAL: begin
          held_value_next = b;
          phase_next      = PH_PLEN;
        end
        PH_PLEN: begin
          if (cur_held == PAIR_LITERAL) begin
            literal_left_next = CountW'(b) + CountW'(1);
            phase_next        = PH_LIT;
          end else begin
            em_req     = 1'b1;
            em_val     = cur_held;
            em_len     = CountW'(b) + CountW'(1);
            eor_req    = 1'b1;
            phase_next = PH_PVAL;
          end
        end
        PH_LIT: begin
          em_req            = 1'b1;
          literal_left_next = lit_dec;
          if (lit_dec == '0) begin
            eor_req    = 1'b1;
            phase_next = (cur_held == PAIR_LITERAL) ? PH_PVAL : PH_PACK;
          end
        end
        PH_SKLO: begin
          held_value_next = b;
          phase_next      = PH_SKHI;
        end
        PH_SKHI: begin
          held_value_next = PACK_HELD;
          if (skip_len < MIN_SKIP) begin
            err       = 1'b1;
            done_next = 1'b1;
          end else if (skip_len == MIN_SKIP) begin
            phase_next = PH_PACK;
          end else begin
            skip_left_next = SKW'(skip_len - MIN_SKIP);
            phase_next     = PH_SKIP;
          end
        end
        PH_PACK: begin
          if (b[7:5] == PACK_LITERAL) begin
            held_value_next   = PACK_HELD;
            literal_left_next = CountW'(b[4:0]) + CountW'(1);
            phase_next        = PH_LIT;
          end else begin
            em_req  = 1'b1;
            em_val  = ByteW'(b[7:5]);
            em_len  = CountW'(b[4:0]) + CountW'(1);
            eor_req = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Clip the run at the row end
    avail     = (cur_col < w_c) ? CMPW'(w_c - cur_col) : '0;
    len_x     = CMPW'(em_len);
    cnt       = (len_x < avail) ? em_len : CountW'(avail);
    emit      = em_req && (cnt != '0);
    col_sum   = CMPW'(cur_col) + CMPW'(cnt);
    col_after = emit ? col_sum[DW-1:0] : cur_col;
    row_p1    = (DW+1)'(cur_row) + (DW+1)'(1);
    lst       = (row_p1 >= (DW+1)'(h_c)) && (col_sum >= CMPW'(w_c));

    // Close the row once it is full
    col_next = col_after;
    row_next = cur_row;
    if (eor_req && (col_after >= w_c)) begin
      col_next = '0;
      row_next = row_p1[DW-1:0];
      if (row_p1 >= (DW+1)'(h_c)) begin
        done_next = 1'b1;
      end
    end

    fire = emit || err;
  end

  // Update decoder state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_RAW;
      col          <= '0;
      row          <= '0;
      literal_left <= '0;
      held_value   <= '0;
      skip_left    <= '0;
      done         <= 1'b0;
    end else if (item_take) begin
      phase        <= phase_next;
      col          <= col_next;
      row          <= row_next;
      literal_left <= literal_left_next;
      held_value   <= held_value_next;
      skip_left    <= skip_left_next;
      done         <= done_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
    end else if (item_take) begin
      run_valid <= fire;
    end else if (!run_stall) begin
      run_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && fire) begin
      if (err) begin
        pixel_value <= '0;
        run_count   <= '0;
        pos_x       <= '0;
        pos_y       <= '0;
        last        <= 1'b0;
        status      <= ST_SHORT_SKIP;
      end else begin
        pixel_value <= em_val;
        run_count   <= cnt;
        pos_x       <= PosW'(cur_col);
        pos_y       <= PosW'(cur_row);
        last        <= lst;
        status      <= ST_OK;
      end
    end
  end

endmodule
